[rtl/cursor_line_editor_macros.svh]
// ----------------------------------------------------------------------------
// Cursor line editor assertion macros
// Shared macros for the concurrent checks on the editor's ports.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINE_EDITOR_MACROS_SVH
`define CURSOR_LINE_EDITOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define CLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor line editor check failed");

// Check a consequent in the cycle after its antecedent.
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor line editor check failed");

`endif

[rtl/cle_pkg.sv]
// ----------------------------------------------------------------------------
// Cursor line editor package
// Shared constants, keystroke codes and types of the line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [7:0] KEY_LEFT  = 8'd60;
    localparam logic [7:0] KEY_RIGHT = 8'd62;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LEFT,
        OP_RIGHT
    } op_t;

    // One classified keystroke word.
    typedef struct packed {
        op_t        op;
        logic [7:0] key;
        logic       line_end;
    } cmd_t;

    // Queue status as seen by the front and the back.
    typedef struct packed {
        logic nonempty;
        logic full;
    } q_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE_L,
        S_MOVE_R,
        S_EMIT
    } back_state_t;

endpackage

[rtl/cursor_line_editor.sv]
// ----------------------------------------------------------------------------
// Cursor line editor
// Gap buffer line editor with a cursor between two character stacks.
// ----------------------------------------------------------------------------
// A keystroke word (key, line_end) is taken at a rising edge where start is
// high and busy is low. '<' moves the cursor one character left, '>' one
// character right, and any other byte is inserted at the cursor. An insert
// into a full line is dropped and marks the line as overflowed.
// The word that carries line_end emits the edited line left to right, one
// character word per cycle with out_valid high for exactly one cycle each;
// out_last marks the final word and a line with no text gives a single word
// with out_empty set. The receiver cannot stall, so results simply stream.
// A front stage classifies keys and feeds a four-entry queue; the back end
// runs one insert per cycle while it is idle and the queue holds words, and
// a cursor move as a registered stack memory read followed by the write to
// the other stack. Once its keystroke is executed, an emit delivers one
// character per cycle. busy rises only when the queue and the front stage
// are both full. Reset clears the counts, the overflow flag and the queue;
// the stack memories need no clearing since the counts cover written
// entries only.
// ----------------------------------------------------------------------------
module cursor_line_editor #(
    parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  key,
    input  logic        line_end,
    output logic        out_valid,
    output logic [7:0]  out_char,
    output logic        out_empty,
    output logic        out_overflow,
    output logic        out_last
);

    cle_pkg::q_stat_t q_stat;
    cle_pkg::cmd_t    push_cmd;
    cle_pkg::cmd_t    head_cmd;
    logic             push;
    logic             pop;

    // Front end: accept and classify keystrokes.
    cle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .key      (key),
        .line_end (line_end),
        .q_stat   (q_stat),
        .busy     (busy),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue that decouples the front end from the stack engine.
    cle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // Back end: stack engine and line emitter.
    cle_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_char     (out_char),
        .out_empty    (out_empty),
        .out_overflow (out_overflow),
        .out_last     (out_last)
    );

endmodule

[rtl/cle_front.sv]
// ----------------------------------------------------------------------------
// Cursor line editor front end
// Accepts keystroke words, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module cle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [7:0]          key,
    input  logic                line_end,
    input  cle_pkg::q_stat_t    q_stat,
    output logic                busy,
    output logic                push,
    output cle_pkg::cmd_t       push_cmd
);

    logic          fv_reg;
    logic          fv_next;
    cle_pkg::cmd_t fcmd_reg;
    cle_pkg::cmd_t fcmd_next;
    logic          accept;

    assign busy     = fv_reg && q_stat.full;
    assign accept   = start && !busy;
    assign push     = fv_reg && !q_stat.full;
    assign push_cmd = fcmd_reg;

    always_comb
    begin
        fv_next   = fv_reg;
        fcmd_next = fcmd_reg;
        if (accept)
        begin
            fv_next            = 1'b1;
            fcmd_next.key      = key;
            fcmd_next.line_end = line_end;
            if (key == cle_pkg::KEY_LEFT)
                fcmd_next.op = cle_pkg::OP_LEFT;
            else if (key == cle_pkg::KEY_RIGHT)
                fcmd_next.op = cle_pkg::OP_RIGHT;
            else
                fcmd_next.op = cle_pkg::OP_INSERT;
        end
        else if (push)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= fv_next;
    end

    always_ff @(posedge clk)
    begin
        fcmd_reg <= fcmd_next;
    end

endmodule

[rtl/cle_queue.sv]
// ----------------------------------------------------------------------------
// Cursor line editor command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module cle_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cle_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output cle_pkg::cmd_t       head_cmd,
    output cle_pkg::q_stat_t    q_stat
);

    cle_pkg::cmd_t              entry_reg [cle_pkg::QDEPTH];
    logic [cle_pkg::QAW-1:0]    wr_ptr_reg;
    logic [cle_pkg::QAW-1:0]    wr_ptr_next;
    logic [cle_pkg::QAW-1:0]    rd_ptr_reg;
    logic [cle_pkg::QAW-1:0]    rd_ptr_next;
    logic [cle_pkg::QAW:0]      count_reg;
    logic [cle_pkg::QAW:0]      count_next;
    logic                       do_push;
    logic                       do_pop;

    assign q_stat.full     = (count_reg == (cle_pkg::QAW+1)'(cle_pkg::QDEPTH));
    assign q_stat.nonempty = (count_reg != '0);
    assign head_cmd        = entry_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.nonempty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/cle_back.sv]
// ----------------------------------------------------------------------------
// Cursor line editor back end
// Executes queued keystrokes on the two stacks and emits finished lines.
// ----------------------------------------------------------------------------
module cle_back #(
    parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cle_pkg::cmd_t       head_cmd,
    input  cle_pkg::q_stat_t    q_stat,
    output logic                pop,
    output logic                out_valid,
    output logic [7:0]          out_char,
    output logic                out_empty,
    output logic                out_overflow,
    output logic                out_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    cle_pkg::back_state_t state_reg;
    cle_pkg::back_state_t state_next;

    logic [7:0]     left_mem  [CAPACITY];
    logic [7:0]     right_mem [CAPACITY];
    logic [7:0]     rdata_l_reg;
    logic [7:0]     rdata_r_reg;

    logic [CW-1:0]  lc_reg;
    logic [CW-1:0]  lc_next;
    logic [CW-1:0]  rc_reg;
    logic [CW-1:0]  rc_next;
    logic [CW-1:0]  k_reg;
    logic [CW-1:0]  k_next;
    logic           ovf_reg;
    logic           ovf_next;
    logic           le_reg;
    logic           le_next;

    logic           pv_reg;
    logic           pv_next;
    logic           psrc_r_reg;
    logic           psrc_r_next;
    logic           pempty_reg;
    logic           pempty_next;
    logic           plast_reg;
    logic           plast_next;
    logic           povf_reg;
    logic           povf_next;

    logic [CW:0]    sum;
    logic [CW-1:0]  total;
    logic [CW-1:0]  ridx;
    logic           line_full;
    logic           emit_last;

    logic           l_we;
    logic [AW-1:0]  l_waddr;
    logic [7:0]     l_wdata;
    logic [AW-1:0]  l_raddr;
    logic           r_we;
    logic [AW-1:0]  r_waddr;
    logic [AW-1:0]  r_raddr;

    assign sum       = {1'b0, lc_reg} + {1'b0, rc_reg};
    assign total     = sum[CW-1:0];
    assign ridx      = total - CW'(1) - k_reg;
    assign line_full = (total >= CW'(CAPACITY));
    assign emit_last = (k_reg == total - CW'(1));
    assign pop       = (state_reg == cle_pkg::S_IDLE) && q_stat.nonempty;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cle_pkg::S_IDLE:
            begin
                if (pop)
                begin
                    priority if (head_cmd.op == cle_pkg::OP_LEFT && lc_reg != '0)
                        state_next = cle_pkg::S_MOVE_L;
                    else if (head_cmd.op == cle_pkg::OP_RIGHT && rc_reg != '0)
                        state_next = cle_pkg::S_MOVE_R;
                    else if (head_cmd.line_end)
                        state_next = cle_pkg::S_EMIT;
                    else
                        state_next = cle_pkg::S_IDLE;
                end
            end
            cle_pkg::S_MOVE_L,
            cle_pkg::S_MOVE_R:
                state_next = le_reg ? cle_pkg::S_EMIT : cle_pkg::S_IDLE;
            cle_pkg::S_EMIT:
            begin
                if (total == '0 || emit_last)
                    state_next = cle_pkg::S_IDLE;
            end
            default:
                state_next = cle_pkg::S_IDLE;
        endcase
    end

    // Datapath controls and counter updates.
    always_comb
    begin
        lc_next     = lc_reg;
        rc_next     = rc_reg;
        k_next      = '0;
        ovf_next    = ovf_reg;
        le_next     = le_reg;
        pv_next     = 1'b0;
        psrc_r_next = psrc_r_reg;
        pempty_next = 1'b0;
        plast_next  = 1'b0;
        povf_next   = povf_reg;
        l_we        = 1'b0;
        l_waddr     = lc_reg[AW-1:0];
        l_wdata     = head_cmd.key;
        l_raddr     = k_reg[AW-1:0];
        r_we        = 1'b0;
        r_waddr     = rc_reg[AW-1:0];
        r_raddr     = ridx[AW-1:0];
        unique case (state_reg)
            cle_pkg::S_IDLE:
            begin
                if (pop)
                begin
                    le_next = head_cmd.line_end;
                    unique case (head_cmd.op)
                        cle_pkg::OP_LEFT:
                        begin
                            if (lc_reg != '0)
                            begin
                                lc_next = lc_reg - CW'(1);
                                l_raddr = lc_next[AW-1:0];
                            end
                        end
                        cle_pkg::OP_RIGHT:
                        begin
                            if (rc_reg != '0)
                            begin
                                rc_next = rc_reg - CW'(1);
                                r_raddr = rc_next[AW-1:0];
                            end
                        end
                        cle_pkg::OP_INSERT:
                        begin
                            if (line_full)
                                ovf_next = 1'b1;
                            else
                            begin
                                l_we    = 1'b1;
                                lc_next = lc_reg + CW'(1);
                            end
                        end
                        default:
                            le_next = head_cmd.line_end;
                    endcase
                end
            end
            cle_pkg::S_MOVE_L:
            begin
                r_we    = 1'b1;
                rc_next = rc_reg + CW'(1);
            end
            cle_pkg::S_MOVE_R:
            begin
                l_we    = 1'b1;
                l_wdata = rdata_r_reg;
                lc_next = lc_reg + CW'(1);
            end
            cle_pkg::S_EMIT:
            begin
                pv_next   = 1'b1;
                povf_next = ovf_reg;
                if (total == '0)
                begin
                    pempty_next = 1'b1;
                    plast_next  = 1'b1;
                    ovf_next    = 1'b0;
                end
                else
                begin
                    psrc_r_next = (k_reg >= lc_reg);
                    plast_next  = emit_last;
                    if (emit_last)
                    begin
                        lc_next  = '0;
                        rc_next  = '0;
                        ovf_next = 1'b0;
                    end
                    else
                    begin
                        k_next = k_reg + CW'(1);
                    end
                end
            end
            default:
                pv_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cle_pkg::S_IDLE;
            lc_reg    <= '0;
            rc_reg    <= '0;
            k_reg     <= '0;
            ovf_reg   <= 1'b0;
            le_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            rc_reg    <= rc_next;
            k_reg     <= k_next;
            ovf_reg   <= ovf_next;
            le_reg    <= le_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        psrc_r_reg <= psrc_r_next;
        pempty_reg <= pempty_next;
        plast_reg  <= plast_next;
        povf_reg   <= povf_next;
    end

    // Left stack memory.
    always_ff @(posedge clk)
    begin
        if (l_we)
            left_mem[l_waddr] <= l_wdata;
        rdata_l_reg <= left_mem[l_raddr];
    end

    // Right stack memory.
    always_ff @(posedge clk)
    begin
        if (r_we)
            right_mem[r_waddr] <= rdata_l_reg;
        rdata_r_reg <= right_mem[r_raddr];
    end

    assign out_valid    = pv_reg;
    assign out_empty    = pempty_reg;
    assign out_last     = plast_reg;
    assign out_overflow = povf_reg;
    assign out_char     = pempty_reg ? 8'd0 : (psrc_r_reg ? rdata_r_reg : rdata_l_reg);

endmodule

[rtl/cle_checker.sv]
// ----------------------------------------------------------------------------
// Cursor line editor port checker
// Concurrent checks on the result stream seen at the editor's ports.
// ----------------------------------------------------------------------------
`include "cursor_line_editor_macros.svh"

module cle_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic [7:0]  out_char,
    input  logic        out_empty,
    input  logic        out_overflow,
    input  logic        out_last
);

    // An empty line is a single word with a zero character.
    `CLE_ASSERT_NOW(a_empty_single, clk, rst_n, out_valid && out_empty, out_last && out_char == 8'd0)
    // A dropped insert needs a full line, so an empty line never overflows.
    `CLE_ASSERT_NOW(a_empty_no_ovf, clk, rst_n, out_valid && out_empty, !out_overflow)
    // A line streams without gaps until its last word.
    `CLE_ASSERT_NEXT(a_line_contig, clk, rst_n, out_valid && !out_last, out_valid && !out_empty)
    // The overflow mark is the same on every word of one line.
    `CLE_ASSERT_NEXT(a_ovf_steady, clk, rst_n, out_valid && !out_last, $stable(out_overflow))

endmodule

bind cursor_line_editor cle_checker u_cle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_char     (out_char),
    .out_empty    (out_empty),
    .out_overflow (out_overflow),
    .out_last     (out_last)
);
